FILE: rtl/core/lzss_pkg.sv
package lzss_pkg;

    localparam int unsigned OFFSET_BITS = 13;
    localparam int unsigned LEN_BITS    = 4;
    localparam int unsigned LIT_BITS    = 8;
    localparam int unsigned MIN_MATCH   = 3;
    localparam int unsigned COUNT_BITS  = 5;   // holds MIN_MATCH + 15

    // parser phases
    localparam logic [1:0] PH_FLAG   = 2'd0;
    localparam logic [1:0] PH_LIT    = 2'd1;
    localparam logic [1:0] PH_OFFSET = 2'd2;
    localparam logic [1:0] PH_LENGTH = 2'd3;

    // parser event kinds
    localparam logic [1:0] EVT_NONE  = 2'd0;
    localparam logic [1:0] EVT_LIT   = 2'd1;
    localparam logic [1:0] EVT_EOS   = 2'd2;
    localparam logic [1:0] EVT_MATCH = 2'd3;

    typedef struct packed {
        logic [1:0]             kind;
        logic [LIT_BITS-1:0]    lit;
        logic [OFFSET_BITS-1:0] offset;
        logic [COUNT_BITS-1:0]  count;
    } t_parse_evt;

endpackage

FILE: rtl/core/lzss_stream_decoder.sv
// Channel   | Dir | tdata            | tlast        | tuser
// s_axis    | in  | [7:0] data_byte  | -            | -
// m_axis    | out | [7:0] out_byte   | last_in_run  | end_of_stream
//
// A compressed byte is accepted, then parsed one bit per cycle, paused while a parsed
// item is emitted. A literal or an end marker adds an emit state; an end marker drops
// the rest of its byte. A match adds, per copied byte, a history read, then write/emit,
// for up to 18 bytes; the single history read/write pair sets the copy rate.
// After reset a clearing pass zeroes history, input not ready.
// Output stalls hold the sequencer; history is kept across streams.
module lzss_stream_decoder #(
    parameter int unsigned HISTORY_DEPTH = 8192
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,   // [7:0] data_byte
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata,   // [7:0] out_byte
    output logic       o_m_axis_tlast,   // last_in_run
    output logic       o_m_axis_tuser    // end_of_stream
);

    localparam int unsigned AW = $clog2(HISTORY_DEPTH);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_BIT   = 3'd2;
    localparam logic [2:0] ST_RD    = 3'd3;
    localparam logic [2:0] ST_WR    = 3'd4;
    localparam logic [2:0] ST_LIT   = 3'd5;
    localparam logic [2:0] ST_EOS   = 3'd6;

    logic [2:0]                          r_state, n_state;
    logic [7:0]                          r_byte;
    logic [3:0]                          r_nbits;
    logic [AW-1:0]                       r_clr_addr;
    logic [AW-1:0]                       r_wp;
    logic [AW-1:0]                       r_copy_addr;
    logic [lzss_pkg::COUNT_BITS-1:0]     r_copy_cnt;
    logic [7:0]                          r_lit;

    // output register
    logic       r_out_valid;
    logic [7:0] r_out_byte;
    logic       r_out_last;
    logic       r_out_eos;

    // history memory
    logic [7:0]    r_hist [HISTORY_DEPTH];
    logic [7:0]    r_rd_data;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [7:0]    mem_wdata;

    lzss_pkg::t_parse_evt evt;
    logic                 bit_step;
    logic                 can_load;
    logic                 s_accept;

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign bit_step        = (r_state == ST_BIT);
    assign can_load        = !r_out_valid || i_m_axis_tready;

    lzss_bit_parse u_parse (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (bit_step),
        .i_bit   (r_byte[7]),
        .o_evt   (evt)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: if (r_clr_addr == AW'(HISTORY_DEPTH - 1)) n_state = ST_IDLE;
            ST_IDLE:  if (i_s_axis_tvalid) n_state = ST_BIT;
            ST_BIT: begin
                unique case (evt.kind)
                    lzss_pkg::EVT_LIT:   n_state = ST_LIT;
                    lzss_pkg::EVT_EOS:   n_state = ST_EOS;
                    lzss_pkg::EVT_MATCH: n_state = ST_RD;
                    default:             n_state = (r_nbits == 4'd1) ? ST_IDLE : ST_BIT;
                endcase
            end
            ST_RD:    n_state = ST_WR;
            ST_WR: begin
                if (can_load) begin
                    if (r_copy_cnt != lzss_pkg::COUNT_BITS'(1)) n_state = ST_RD;
                    else n_state = (r_nbits == 4'd0) ? ST_IDLE : ST_BIT;
                end
            end
            ST_LIT:   if (can_load) n_state = (r_nbits == 4'd0) ? ST_IDLE : ST_BIT;
            ST_EOS:   if (can_load) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // history write port: clearing pass, literal and copy writes
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_wp;
        mem_wdata = r_rd_data;
        priority if (r_state == ST_CLEAR) begin
            mem_we    = 1'b1;
            mem_waddr = r_clr_addr;
            mem_wdata = '0;
        end else if (r_state == ST_LIT && can_load) begin
            mem_we    = 1'b1;
            mem_wdata = r_lit;
        end else if (r_state == ST_WR && can_load) begin
            mem_we    = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) r_hist[mem_waddr] <= mem_wdata;
        if (r_state == ST_RD) r_rd_data <= r_hist[r_copy_addr];
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_wp        <= AW'(1);
            r_nbits     <= '0;
            r_copy_cnt  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) r_clr_addr <= r_clr_addr + AW'(1);
            if (s_accept) begin
                r_byte  <= i_s_axis_tdata;
                r_nbits <= 4'd8;
            end
            if (bit_step) begin
                r_byte  <= {r_byte[6:0], 1'b0};
                r_nbits <= r_nbits - 4'd1;
                if (evt.kind == lzss_pkg::EVT_LIT) r_lit <= evt.lit;
                if (evt.kind == lzss_pkg::EVT_MATCH) begin
                    r_copy_addr <= evt.offset[AW-1:0];
                    r_copy_cnt  <= evt.count;
                end
            end

            // output register empties or reloads whenever it can take a new item
            if (can_load) begin
                unique case (r_state)
                    ST_LIT: begin
                        r_out_valid <= 1'b1;
                        r_out_byte  <= r_lit;
                        r_out_last  <= 1'b1;
                        r_out_eos   <= 1'b0;
                        r_wp        <= r_wp + AW'(1);
                    end
                    ST_WR: begin
                        r_out_valid <= 1'b1;
                        r_out_byte  <= r_rd_data;
                        r_out_last  <= (r_copy_cnt == lzss_pkg::COUNT_BITS'(1));
                        r_out_eos   <= 1'b0;
                        r_wp        <= r_wp + AW'(1);
                        r_copy_addr <= r_copy_addr + AW'(1);
                        r_copy_cnt  <= r_copy_cnt - lzss_pkg::COUNT_BITS'(1);
                    end
                    ST_EOS: begin
                        // end marker: write position restarts at 1
                        r_out_valid <= 1'b1;
                        r_out_byte  <= '0;
                        r_out_last  <= 1'b1;
                        r_out_eos   <= 1'b1;
                        r_wp        <= AW'(1);
                    end
                    default: r_out_valid <= 1'b0;
                endcase
            end
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_byte;
    assign o_m_axis_tlast  = r_out_last;
    assign o_m_axis_tuser  = r_out_eos;

`ifndef ASSERT_OFF
    a_idle_no_copy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_axis_tready |-> (r_copy_cnt == '0))
        else $error("copy still pending while ready");

    a_eos_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser) |-> (o_m_axis_tlast && o_m_axis_tdata == '0))
        else $error("end marker item malformed");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("ready while a byte is being parsed");
`endif

endmodule

FILE: rtl/core/lzss_bit_parse.sv
// One compressed bit per step; reports the item completed by that bit.
module lzss_bit_parse (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_step,
    input  logic                  i_bit,
    output lzss_pkg::t_parse_evt  o_evt
);

    logic [1:0]                       r_phase, n_phase;
    logic [lzss_pkg::OFFSET_BITS-1:0] r_acc, n_acc;
    logic [3:0]                       r_rem, n_rem;
    logic [lzss_pkg::OFFSET_BITS-1:0] r_off, n_off;

    logic [lzss_pkg::OFFSET_BITS-1:0] acc_sh;
    logic [3:0]                       rem_dec;

    always_comb begin
        acc_sh  = {r_acc[lzss_pkg::OFFSET_BITS-2:0], i_bit};
        rem_dec = r_rem - 4'd1;
        n_phase = r_phase;
        n_acc   = r_acc;
        n_rem   = r_rem;
        n_off   = r_off;
        o_evt.kind   = lzss_pkg::EVT_NONE;
        o_evt.lit    = acc_sh[lzss_pkg::LIT_BITS-1:0];
        o_evt.offset = r_off;
        o_evt.count  = lzss_pkg::COUNT_BITS'(acc_sh[lzss_pkg::LEN_BITS-1:0])
                       + lzss_pkg::COUNT_BITS'(lzss_pkg::MIN_MATCH);
        if (i_step) begin
            if (r_phase == lzss_pkg::PH_FLAG) begin
                n_phase = i_bit ? lzss_pkg::PH_LIT : lzss_pkg::PH_OFFSET;
                n_rem   = i_bit ? 4'(lzss_pkg::LIT_BITS) : 4'(lzss_pkg::OFFSET_BITS);
                n_acc   = '0;
            end else if (rem_dec != 4'd0) begin
                n_acc = acc_sh;
                n_rem = rem_dec;
            end else begin
                n_rem   = rem_dec;
                n_acc   = '0;
                n_phase = lzss_pkg::PH_FLAG;
                unique case (r_phase)
                    lzss_pkg::PH_LIT: begin
                        o_evt.kind = lzss_pkg::EVT_LIT;
                    end
                    lzss_pkg::PH_OFFSET: begin
                        if (acc_sh == '0) begin
                            o_evt.kind = lzss_pkg::EVT_EOS;
                        end else begin
                            n_off   = acc_sh;
                            n_rem   = 4'(lzss_pkg::LEN_BITS);
                            n_phase = lzss_pkg::PH_LENGTH;
                        end
                    end
                    default: begin
                        o_evt.kind = lzss_pkg::EVT_MATCH;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= lzss_pkg::PH_FLAG;
            r_acc   <= '0;
            r_rem   <= '0;
            r_off   <= '0;
        end else begin
            r_phase <= n_phase;
            r_acc   <= n_acc;
            r_rem   <= n_rem;
            r_off   <= n_off;
        end
    end

endmodule
